FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the request handler.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on clk, switched off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication sampled on clk, switched off while rst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: src/usr_pkg.sv
// ---------------------------------------------------------------------------
// usr_pkg
// Types and codes for the standard setup request handler.
// ---------------------------------------------------------------------------
package usr_pkg;

  // Reset value of the highest answered string descriptor index
  localparam logic [7:0] MAX_STRING_INDEX_RST = 8'd3;

  // Request type fields, recipient codes and the address limit
  localparam logic [7:0] TYPE_MASK  = 8'h60;
  localparam logic [7:0] RECIP_MASK = 8'h1F;
  localparam logic [4:0] RECIP_DEVICE    = 5'd0;
  localparam logic [4:0] RECIP_ENDPOINT  = 5'd2;
  localparam logic [15:0] ADDR_MAX = 16'd127;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

  // Descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;

  typedef enum logic [1:0] {
    ACT_STALL = 2'd0,
    ACT_ZLP   = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_DESC  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DEFAULT    = 2'd0,
    ST_ADDRESS    = 2'd1,
    ST_CONFIGURED = 2'd2
  } dev_state_t;

  // One setup packet
  typedef struct packed {
    logic [15:0] request_length;
    logic [15:0] request_index;
    logic [15:0] request_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
  } setup_t;

  // One decoded answer
  typedef struct packed {
    action_t     action;
    logic [1:0]  reply_bytes;
    logic [15:0] reply_data;
    logic        address_update;
    logic [6:0]  device_address;
    dev_state_t  device_state;
    logic [7:0]  descriptor_type;
    logic [7:0]  descriptor_index;
    logic [15:0] length_limit;
  } answer_t;

endpackage

FILE: src/usr_decode.sv
// ---------------------------------------------------------------------------
// usr_decode
// Combinational decode of one setup packet against the device state.
// ---------------------------------------------------------------------------
module usr_decode
  import usr_pkg::*;
(
  input  setup_t     setup,
  input  dev_state_t state_cur,
  input  logic [6:0] addr_cur,
  input  logic [7:0] max_string_index,
  output answer_t    answer,
  output dev_state_t state_nxt,
  output logic [6:0] addr_nxt
);

  logic [4:0] recip;
  logic       type_std;
  logic       recip_ok;
  logic [7:0] hi;
  logic [7:0] lo;
  logic       desc_ok;

  assign recip    = setup.request_type[4:0] & RECIP_MASK[4:0];
  assign type_std = (setup.request_type & TYPE_MASK) == 8'h00;
  assign recip_ok = recip <= RECIP_ENDPOINT;
  assign hi       = setup.request_value[15:8];
  assign lo       = setup.request_value[7:0];

  // Check the requested descriptor against what the device offers
  always_comb begin
    case (hi)
      DESC_DEVICE: desc_ok = 1'b1;
      DESC_CONFIG: desc_ok = (lo == 8'h00);
      DESC_STRING: desc_ok = (lo == 8'h00) || (lo <= max_string_index);
      default:     desc_ok = 1'b0;
    endcase
  end

  // Decode the request and work out the next device state
  always_comb begin
    answer    = '0;
    answer.action = ACT_STALL;
    state_nxt = state_cur;
    addr_nxt  = addr_cur;
    if (type_std) begin
      case (setup.request_code)
        REQ_GET_STATUS: begin
          if (recip_ok) begin
            answer.action      = ACT_DATA;
            answer.reply_bytes = 2'd2;
          end
        end
        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
          if (recip_ok) answer.action = ACT_ZLP;
        end
        REQ_SET_ADDRESS: begin
          if (recip == RECIP_DEVICE && setup.request_value <= ADDR_MAX &&
              setup.request_index == 16'h0000 && setup.request_length == 16'h0000) begin
            addr_nxt  = setup.request_value[6:0];
            state_nxt = (setup.request_value == 16'h0000) ? ST_DEFAULT : ST_ADDRESS;
            answer.address_update = 1'b1;
            answer.action         = ACT_ZLP;
          end
        end
        REQ_GET_DESCRIPTOR: begin
          if (recip == RECIP_DEVICE && desc_ok) begin
            answer.action           = ACT_DESC;
            answer.descriptor_type  = hi;
            answer.descriptor_index = lo;
            answer.length_limit     = setup.request_length;
          end
        end
        REQ_GET_CONFIGURATION: begin
          if (setup.request_value == 16'h0000 && setup.request_index == 16'h0000 &&
              setup.request_length == 16'd1) begin
            answer.action      = ACT_DATA;
            answer.reply_bytes = 2'd1;
            answer.reply_data  = {15'd0, state_cur == ST_CONFIGURED};
          end
        end
        REQ_SET_CONFIGURATION: begin
          if (hi == 8'h00 && setup.request_index == 16'h0000 &&
              setup.request_length == 16'h0000) begin
            state_nxt     = (lo == 8'h00) ? ST_ADDRESS : ST_CONFIGURED;
            answer.action = ACT_ZLP;
          end
        end
        default: begin
          answer.action = ACT_STALL;
        end
      endcase
    end
    answer.device_address = addr_nxt;
    answer.device_state   = state_nxt;
  end

endmodule

FILE: src/usb_standard_request_handler.sv
// ---------------------------------------------------------------------------
// usb_standard_request_handler
// Standard setup request decoder keeping device state and address.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one setup packet per beat, tdata from bit 0 up: request_type,
//           request_code, request_value, request_index, request_length.
//   out_* : one answer per packet; tuser carries the action code, tdata the
//           reply and state fields.
//   cfg_* : write of max_string_index, always ready; write it while idle.
// Path: the input beat is held in the input register, then its answer in
//   the result register, which drives out_*.
// Throughput: one packet per cycle while out_tready is high; the only logic
//   between the two registers is the request decode and the state update.
// Reset: device state default, address 0, max_string_index 3, both
//   pipeline registers empty.
// Stall: while out_tready is low the answer holds; one more packet waits in
//   the input register, after which in_tready drops.
// ---------------------------------------------------------------------------
module usb_standard_request_handler
  import usr_pkg::*;
#(
  parameter logic [7:0] MaxStringIndexRst = MAX_STRING_INDEX_RST
) (
  input  logic        clk,
  input  logic        rst_n,
  // setup packet
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] request_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_index, [63:48] request_length
  input  logic [63:0] in_tdata,
  // answer
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] action
  output logic [1:0]  out_tuser,
  // [1:0] reply_bytes, [17:2] reply_data, [18] address_update,
  // [25:19] device_address, [27:26] device_state, [35:28] descriptor_type,
  // [43:36] descriptor_index, [59:44] length_limit, [63:60] zero
  output logic [63:0] out_tdata,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  `include "assert_macros.svh"

  logic       in_valid_r;
  setup_t     in_r;
  logic       out_valid_r;
  answer_t    out_r;
  dev_state_t state_r;
  logic [6:0] addr_r;
  logic [7:0] max_string_index_r;

  answer_t    answer;
  dev_state_t state_nxt;
  logic [6:0] addr_nxt;
  logic       advance;

  // Move the held packet on when the result register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  usr_decode u_decode (
    .setup            (in_r),
    .state_cur        (state_r),
    .addr_cur         (addr_r),
    .max_string_index (max_string_index_r),
    .answer           (answer),
    .state_nxt        (state_nxt),
    .addr_nxt         (addr_nxt)
  );

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_string_index_r <= MaxStringIndexRst;
    end else if (cfg_valid && cfg_ready) begin
      max_string_index_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= setup_t'(in_tdata);
    end
  end

  // Update device state as each packet is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DEFAULT;
      addr_r  <= 7'd0;
    end else if (advance) begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= answer;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.action;
  assign out_tdata  = {4'd0, out_r.length_limit, out_r.descriptor_index,
                       out_r.descriptor_type, out_r.device_state, out_r.device_address,
                       out_r.address_update, out_r.reply_data, out_r.reply_bytes};

  // Reply fields stay clear unless the answer is a data reply
  `ASSERT_IMPL(a_reply_only_data, out_valid_r && out_r.action != ACT_DATA, out_r.reply_bytes == 2'd0 && out_r.reply_data == 16'h0000, "reply fields set without a data reply")
  // An address change is always acknowledged with zero-length status
  `ASSERT_IMPL(a_addr_update_zlp, out_valid_r && out_r.address_update, out_r.action == ACT_ZLP && out_r.device_address == addr_r, "address update without status or with stale address")
  // Never take a packet while both registers are full and stalled
  `ASSERT_IMPL(a_no_overrun, in_valid_r && out_valid_r && !out_tready, !in_tready, "input taken while pipeline is full")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the standard setup request handler.
// Setup packets are driven on the input stream. A local predictor keeps its
// own copy of the device state, the address and the string index limit, and
// queues one expected answer per accepted packet. Each answer beat is checked
// field by field. Directed packets cover every request and its stall cases,
// those of Get Configuration apart; random packets run under several idle and
// stall patterns and under one long output hold-off.
// ---------------------------------------------------------------------------
module tb;
  import usr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 330;
  localparam int MAX_PRINTED = 40;

  // Codes that the block does not export but the stimulus needs
  localparam logic [4:0] RECIP_IFACE       = 5'd1;
  localparam logic [4:0] RECIP_OTHER       = 5'd3;
  localparam logic [4:0] RECIP_ALL_ONES    = 5'h1F;
  localparam logic [7:0] TYPE_CLASS        = 8'h20;
  localparam logic [7:0] TYPE_VENDOR       = 8'h40;
  localparam logic [7:0] DIR_IN            = 8'h80;
  localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'h07;
  localparam logic [7:0] REQ_SYNCH_FRAME   = 8'h0C;
  localparam logic [7:0] DESC_INTERFACE    = 8'h04;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  out_tuser;
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // Predictor state
  dev_state_t  dev_state;
  logic [6:0]  pred_addr;
  logic [7:0]  max_string;

  answer_t     pending_answers[$];
  int          mismatches;
  int          cycle_count;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          hold_left;

  usb_standard_request_handler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Drive out_tready: a pending hold-off first, then random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  task automatic report_mismatch(string msg);
    mismatches = mismatches + 1;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  // Decode one setup packet and advance the device state
  function automatic answer_t predict_answer(setup_t s);
    answer_t    a;
    logic [4:0] recip;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       recip_known;
    logic       desc_ok;
    a           = '0;
    recip       = s.request_type[4:0];
    hi          = s.request_value[15:8];
    lo          = s.request_value[7:0];
    recip_known = (recip <= RECIP_ENDPOINT);
    if ((s.request_type & TYPE_MASK) == 8'h00) begin
      case (s.request_code)
        REQ_GET_STATUS: begin
          if (recip_known) begin
            a.action      = ACT_DATA;
            a.reply_bytes = 2'd2;
          end
        end
        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
          if (recip_known) a.action = ACT_ZLP;
        end
        REQ_SET_ADDRESS: begin
          if (recip == RECIP_DEVICE && s.request_value <= ADDR_MAX &&
              s.request_index == 16'd0 && s.request_length == 16'd0) begin
            pred_addr        = s.request_value[6:0];
            dev_state        = (s.request_value == 16'd0) ? ST_DEFAULT : ST_ADDRESS;
            a.address_update = 1'b1;
            a.action         = ACT_ZLP;
          end
        end
        REQ_GET_DESCRIPTOR: begin
          desc_ok = (hi == DESC_DEVICE) || (hi == DESC_CONFIG && lo == 8'd0) ||
                    (hi == DESC_STRING && lo <= max_string);
          if (recip == RECIP_DEVICE && desc_ok) begin
            a.action           = ACT_DESC;
            a.descriptor_type  = hi;
            a.descriptor_index = lo;
            a.length_limit     = s.request_length;
          end
        end
        REQ_GET_CONFIGURATION: begin
          if (s.request_value == 16'd0 && s.request_index == 16'd0 &&
              s.request_length == 16'd1) begin
            a.action      = ACT_DATA;
            a.reply_bytes = 2'd1;
            a.reply_data  = {15'd0, dev_state == ST_CONFIGURED};
          end
        end
        REQ_SET_CONFIGURATION: begin
          if (hi == 8'd0 && s.request_index == 16'd0 && s.request_length == 16'd0) begin
            dev_state = (lo == 8'd0) ? ST_ADDRESS : ST_CONFIGURED;
            a.action  = ACT_ZLP;
          end
        end
        default: ;
      endcase
    end
    a.device_address = pred_addr;
    a.device_state   = dev_state;
    return a;
  endfunction

  // Check each answer beat against the oldest expected answer
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("answer beat with no packet outstanding");
      end else begin
        want = pending_answers.pop_front();
        check_field("action", 16'(out_tuser), 16'(want.action));
        check_field("reply_bytes", 16'(out_tdata[1:0]), 16'(want.reply_bytes));
        check_field("reply_data", out_tdata[17:2], want.reply_data);
        check_field("address_update", 16'(out_tdata[18]), 16'(want.address_update));
        check_field("device_address", 16'(out_tdata[25:19]), 16'(want.device_address));
        check_field("device_state", 16'(out_tdata[27:26]), 16'(want.device_state));
        check_field("descriptor_type", 16'(out_tdata[35:28]), 16'(want.descriptor_type));
        check_field("descriptor_index", 16'(out_tdata[43:36]),
                    16'(want.descriptor_index));
        check_field("length_limit", out_tdata[59:44], want.length_limit);
        check_field("padding", 16'(out_tdata[63:60]), 16'd0);
      end
    end
  end

  function automatic setup_t make_setup(logic [7:0] rtype, logic [7:0] code,
                                        logic [15:0] value, logic [15:0] index,
                                        logic [15:0] length);
    setup_t s;
    s.request_type   = rtype;
    s.request_code   = code;
    s.request_value  = value;
    s.request_index  = index;
    s.request_length = length;
    return s;
  endfunction

  function automatic bit rarely();
    return $urandom_range(0, 7) == 0;
  endfunction

  // Mostly well-formed requests with random content, some noise
  function automatic setup_t random_setup();
    setup_t     s;
    logic [7:0] codes [7];
    int         pick;
    codes = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_ADDRESS,
              REQ_GET_DESCRIPTOR, REQ_GET_CONFIGURATION, REQ_SET_CONFIGURATION};
    s    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 12) return s;
    if (pick >= 18) s.request_type[6:5] = 2'b00;
    if ($urandom_range(0, 9) != 0) s.request_type[4:0] = 5'($urandom_range(0, 2));
    if (pick >= 22) s.request_code = codes[$urandom_range(0, 6)];
    case (s.request_code)
      REQ_SET_ADDRESS: begin
        if (!rarely()) s.request_value = rarely() ? 16'd0 : 16'($urandom_range(1, 127));
        if (!rarely()) s.request_index = 16'd0;
        if (!rarely()) s.request_length = 16'd0;
        if (!rarely()) s.request_type[4:0] = RECIP_DEVICE;
      end
      REQ_GET_DESCRIPTOR: begin
        if (!rarely()) s.request_type[4:0] = RECIP_DEVICE;
        if (!rarely())
          s.request_value = {8'($urandom_range(0, 4)),
                             rarely() ? s.request_value[7:0] : 8'($urandom_range(0, 5))};
      end
      REQ_GET_CONFIGURATION: begin
        if (!rarely()) s.request_value = 16'd0;
        if (!rarely()) s.request_index = 16'd0;
        if (!rarely()) s.request_length = 16'd1;
      end
      REQ_SET_CONFIGURATION: begin
        if (!rarely())
          s.request_value = {8'd0, rarely() ? s.request_value[7:0] : 8'($urandom_range(0, 2))};
        if (!rarely()) s.request_index = 16'd0;
        if (!rarely()) s.request_length = 16'd0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Offer one packet after a random gap; called and left at a falling edge
  task automatic send_setup(setup_t s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(predict_answer(s));
    @(negedge clk);
  endtask

  // Drop valid, wait for every answer, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_string(logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_string = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Every request and its stall cases, Get Configuration's apart, from reset state
  task automatic test_directed();
    send_setup(make_setup(8'h00, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
    send_setup(make_setup(DIR_IN | 8'(RECIP_ENDPOINT), REQ_GET_STATUS,
                          16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_setup(make_setup(8'(RECIP_OTHER), REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
    send_setup(make_setup(8'(RECIP_IFACE), REQ_CLEAR_FEATURE, 16'd1, 16'd1, 16'd0));
    send_setup(make_setup(8'(RECIP_ALL_ONES), REQ_SET_FEATURE, 16'd1, 16'd0, 16'd0));
    send_setup(make_setup(TYPE_CLASS, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
    send_setup(make_setup(TYPE_VENDOR, REQ_SET_ADDRESS, 16'd9, 16'd0, 16'd0));
    send_setup(make_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_setup(make_setup(8'h00, REQ_SET_DESCRIPTOR, 16'h0100, 16'd0, 16'd18));
    send_setup(make_setup(8'(RECIP_ENDPOINT), REQ_SYNCH_FRAME, 16'd0, 16'd1, 16'd2));
    // Address limits and the fields that must be zero
    send_setup(make_setup(8'h00, REQ_SET_ADDRESS, 16'd128, 16'd0, 16'd0));
    send_setup(make_setup(8'h00, REQ_SET_ADDRESS, 16'd5, 16'd1, 16'd0));
    send_setup(make_setup(8'h00, REQ_SET_ADDRESS, 16'd5, 16'd0, 16'd1));
    send_setup(make_setup(8'h00, REQ_SET_ADDRESS, 16'd127, 16'd0, 16'd0));
    // Descriptor types and indexes
    send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'hFF}, 16'd0, 16'hFFFF));
    send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'd0, 16'd9));
    send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h01}, 16'd0, 16'd9));
    send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h03}, 16'h0409, 16'd255));
    send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h04}, 16'h0409, 16'd255));
    send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_INTERFACE, 8'h00}, 16'd0, 16'd9));
    // Configuration round trip, then back to the default state
    send_setup(make_setup(8'h00, REQ_SET_CONFIGURATION, 16'h0100, 16'd0, 16'd0));
    send_setup(make_setup(8'h00, REQ_SET_CONFIGURATION, 16'h00FF, 16'd0, 16'd0));
    send_setup(make_setup(DIR_IN, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
    send_setup(make_setup(8'h00, REQ_SET_CONFIGURATION, 16'd0, 16'd0, 16'd0));
    send_setup(make_setup(8'h00, REQ_SET_ADDRESS, 16'd0, 16'd0, 16'd0));
    wait_idle();
  endtask

  // String index limit at its extremes and at a random value
  task automatic test_string_limit();
    logic [7:0] limits [3];
    limits = '{8'd0, 8'd255, 8'($urandom_range(1, 254))};
    foreach (limits[i]) begin
      write_max_string(limits[i]);
      send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'd0}, 16'd0, 16'd4));
      send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, limits[i]},
                            16'h0409, 16'd64));
      send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, limits[i] + 8'd1},
                            16'h0409, 16'd64));
      send_setup(make_setup(DIR_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'hFF},
                            16'h0409, 16'd64));
      wait_idle();
    end
  endtask

  // Random packets under each idle pattern, with a new limit per phase
  task automatic test_random_phases();
    int         src_pct [4];
    int         sink_pct [4];
    logic [7:0] limits [4];
    src_pct  = '{0, 48, 0, 30};
    sink_pct = '{0, 0, 48, 30};
    limits   = '{8'd255, 8'd0, 8'($urandom_range(0, 255)), MAX_STRING_INDEX_RST};
    foreach (src_pct[p]) begin
      write_max_string(limits[p]);
      src_idle_pct   = src_pct[p];
      sink_stall_pct = sink_pct[p];
      repeat (PHASE_ITEMS) send_setup(random_setup());
      wait_idle();
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Hold the output off long enough for the block to stall its input
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 300;
    repeat (40) send_setup(random_setup());
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    mismatches     = 0;
    cycle_count    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    dev_state      = ST_DEFAULT;
    pred_addr      = 7'd0;
    max_string     = MAX_STRING_INDEX_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_string_limit();
    test_backpressure();
    test_random_phases();

    repeat (10) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
